// ===== design/bsat_pkg.sv =====
// Shared constants, result codes and controller/datapath interface types
// for the beacon source aging table. No dependencies.
package bsat_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam int ADDR_W    = 48;
    localparam int FC_W      = 16;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 5;
    localparam int BEACON_W  = 16;
    localparam int LIVE_W    = 6;
    localparam int REMOVED_W = 6;
    localparam int MISSED_W  = 8;

    localparam logic [FC_W-1:0]     BEACON_TYPE  = 16'h0080;
    localparam logic [MISSED_W-1:0] MISSED_RESET = 8'd10;
    localparam logic [IDX_W-1:0]    LAST_IDX     = IDX_W'(TABLE_SLOTS - 1);
    localparam logic                ACT_TICK     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_REFRESH    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_BEACON = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK       = 3'd4;

    typedef struct packed {
        logic load;    // capture a new item
        logic scan;    // step the slot read pointer
        logic probe;   // address lookup pass
        logic age;     // aging pass
        logic commit;  // apply lookup outcome
        logic emit;    // load the output register
    } bsat_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_beacon;
        logic hit_now;
        logic proc_last;
        logic out_free;
    } bsat_stat_t;

endpackage

// ===== design/bsat_ctrl.sv =====
// Sequencing state machine for the beacon source aging table.
// Depends on bsat_pkg; drives bsat_dp through a command struct.
module bsat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bsat_pkg::bsat_stat_t stat,
    output bsat_pkg::bsat_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.is_tick)
                        state_next = S_SWEEP;
                    else if (stat.is_beacon)
                        state_next = S_LOOKUP;
                    else
                        state_next = S_EMIT;
                end
            end
            S_LOOKUP:
            begin
                // stop at the first match or after the last slot
                if (stat.hit_now || stat.proc_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_EMIT;
            end
            S_SWEEP:
            begin
                if (stat.proc_last)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan   = (state_reg == S_LOOKUP) || (state_reg == S_SWEEP);
    assign cmd.probe  = (state_reg == S_LOOKUP);
    assign cmd.age    = (state_reg == S_SWEEP);
    assign cmd.commit = (state_reg == S_DECIDE);
    assign cmd.emit   = (state_reg == S_EMIT) && stat.out_free;

endmodule

// ===== design/bsat_dp.sv =====
// Datapath of the beacon source aging table: slot memories, per-slot flags,
// counters, config register and output register. Depends on bsat_pkg.
module bsat_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bsat_pkg::bsat_cmd_t                 cmd,
    output bsat_pkg::bsat_stat_t                stat,
    input  logic                                action,
    input  logic [bsat_pkg::FC_W-1:0]           fc_word,
    input  logic [bsat_pkg::ADDR_W-1:0]         source_address,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsat_pkg::MISSED_W-1:0]       cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [bsat_pkg::STATUS_W-1:0]       status,
    output logic [bsat_pkg::SLOT_W-1:0]         slot,
    output logic [bsat_pkg::BEACON_W-1:0]       beacon_count,
    output logic [bsat_pkg::LIVE_W-1:0]         live_count,
    output logic [bsat_pkg::REMOVED_W-1:0]      removed_count
);

    // slot memories, one read port at rd_idx_reg
    logic [bsat_pkg::ADDR_W-1:0]   addr_mem    [bsat_pkg::TABLE_SLOTS];
    logic [bsat_pkg::BEACON_W-1:0] beacons_mem [bsat_pkg::TABLE_SLOTS];
    logic [bsat_pkg::MISSED_W-1:0] missed_mem  [bsat_pkg::TABLE_SLOTS];

    logic [bsat_pkg::ADDR_W-1:0]   addr_rd_reg;
    logic [bsat_pkg::BEACON_W-1:0] beacons_rd_reg;
    logic [bsat_pkg::MISSED_W-1:0] missed_rd_reg;

    logic [bsat_pkg::TABLE_SLOTS-1:0] valid_reg;
    logic [bsat_pkg::TABLE_SLOTS-1:0] arrived_reg;
    logic [bsat_pkg::TABLE_SLOTS-1:0] fresh_reg;

    logic [bsat_pkg::MISSED_W-1:0] max_missed_reg;
    logic [bsat_pkg::ADDR_W-1:0]   key_reg;
    logic [bsat_pkg::IDX_W-1:0]    rd_idx_reg;
    logic [bsat_pkg::IDX_W-1:0]    proc_idx_reg;
    logic                          proc_vld_reg;

    logic                          hit_reg;
    logic                          free_reg;
    logic [bsat_pkg::IDX_W-1:0]    hit_idx_reg;
    logic [bsat_pkg::IDX_W-1:0]    free_idx_reg;
    logic [bsat_pkg::BEACON_W-1:0] hit_beacons_reg;

    logic [bsat_pkg::CNT_W-1:0]    live_reg;
    logic [bsat_pkg::CNT_W-1:0]    removed_reg;

    logic [bsat_pkg::STATUS_W-1:0] res_status_reg;
    logic [bsat_pkg::IDX_W-1:0]    res_slot_reg;
    logic [bsat_pkg::BEACON_W-1:0] res_count_reg;

    logic                           out_valid_reg;
    logic [bsat_pkg::STATUS_W-1:0]  out_status_reg;
    logic [bsat_pkg::SLOT_W-1:0]    out_slot_reg;
    logic [bsat_pkg::BEACON_W-1:0]  out_count_reg;
    logic [bsat_pkg::LIVE_W-1:0]    out_live_reg;
    logic [bsat_pkg::REMOVED_W-1:0] out_removed_reg;

    logic                          cur_valid;
    logic                          cur_arrived;
    logic                          cur_fresh;
    logic                          hit_now;
    logic                          free_now;
    logic                          do_insert;
    logic                          do_refresh;
    logic                          aging;
    logic                          expire;
    logic [bsat_pkg::BEACON_W-1:0] new_beacons;

    logic                          beacons_we;
    logic [bsat_pkg::IDX_W-1:0]    beacons_waddr;
    logic [bsat_pkg::BEACON_W-1:0] beacons_wdata;
    logic                          missed_we;
    logic [bsat_pkg::IDX_W-1:0]    missed_waddr;
    logic [bsat_pkg::MISSED_W-1:0] missed_wdata;

    assign cur_valid   = valid_reg[proc_idx_reg];
    assign cur_arrived = arrived_reg[proc_idx_reg];
    assign cur_fresh   = fresh_reg[proc_idx_reg];
    assign hit_now     = proc_vld_reg && cur_valid && (addr_rd_reg == key_reg);
    assign free_now    = proc_vld_reg && !cur_valid;
    assign do_refresh  = cmd.commit && hit_reg;
    assign do_insert   = cmd.commit && !hit_reg && free_reg;
    assign aging       = cmd.age && proc_vld_reg && cur_valid;
    assign expire      = aging && !cur_arrived && !cur_fresh
                         && (missed_rd_reg >= max_missed_reg);
    assign new_beacons = (hit_beacons_reg == '1) ? hit_beacons_reg
                                                 : hit_beacons_reg + 1'b1;

    assign stat.is_tick   = (action == bsat_pkg::ACT_TICK);
    assign stat.is_beacon = (fc_word == bsat_pkg::BEACON_TYPE);
    assign stat.hit_now   = cmd.probe && hit_now;
    assign stat.proc_last = proc_vld_reg && (proc_idx_reg == bsat_pkg::LAST_IDX);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_missed_reg <= bsat_pkg::MISSED_RESET;
        end
        else if (cfg_valid)
        begin
            max_missed_reg <= cfg_data;
        end
    end

    // memory write selection
    always_comb
    begin
        beacons_we    = do_refresh || do_insert;
        beacons_waddr = hit_reg ? hit_idx_reg : free_idx_reg;
        beacons_wdata = hit_reg ? new_beacons : bsat_pkg::BEACON_W'(1);
        missed_we     = do_insert;
        missed_waddr  = free_idx_reg;
        missed_wdata  = '0;
        if (aging && !expire)
        begin
            missed_we    = 1'b1;
            missed_waddr = proc_idx_reg;
            missed_wdata = (cur_arrived || cur_fresh) ? '0 : missed_rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_rd_reg    <= addr_mem[rd_idx_reg];
        beacons_rd_reg <= beacons_mem[rd_idx_reg];
        missed_rd_reg  <= missed_mem[rd_idx_reg];
        if (do_insert)
            addr_mem[free_idx_reg] <= key_reg;
        if (beacons_we)
            beacons_mem[beacons_waddr] <= beacons_wdata;
        if (missed_we)
            missed_mem[missed_waddr] <= missed_wdata;
    end

    // scan pointer and per-slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg   <= '0;
            proc_idx_reg <= '0;
            proc_vld_reg <= 1'b0;
            valid_reg    <= '0;
            arrived_reg  <= '0;
            fresh_reg    <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            live_reg     <= '0;
            removed_reg  <= '0;
        end
        else
        begin
            proc_vld_reg <= cmd.scan;
            proc_idx_reg <= rd_idx_reg;
            if (cmd.load)
                rd_idx_reg <= '0;
            else if (cmd.scan && (rd_idx_reg != bsat_pkg::LAST_IDX))
                rd_idx_reg <= rd_idx_reg + 1'b1;

            if (cmd.load)
            begin
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                removed_reg <= '0;
            end
            else if (cmd.probe)
            begin
                if (hit_now && !hit_reg)
                    hit_reg <= 1'b1;
                if (free_now && !free_reg)
                    free_reg <= 1'b1;
            end

            if (do_refresh)
            begin
                arrived_reg[hit_idx_reg] <= 1'b1;
            end
            else if (do_insert)
            begin
                valid_reg[free_idx_reg]   <= 1'b1;
                arrived_reg[free_idx_reg] <= 1'b1;
                fresh_reg[free_idx_reg]   <= 1'b1;
                live_reg                  <= live_reg + 1'b1;
            end
            else if (aging)
            begin
                arrived_reg[proc_idx_reg] <= 1'b0;
                fresh_reg[proc_idx_reg]   <= 1'b0;
                if (expire)
                begin
                    valid_reg[proc_idx_reg] <= 1'b0;
                    live_reg                <= live_reg - 1'b1;
                    removed_reg             <= removed_reg + 1'b1;
                end
            end
        end
    end

    // lookup capture and pending result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg        <= source_address;
            res_status_reg <= stat.is_tick ? bsat_pkg::ST_TICK : bsat_pkg::ST_NOT_BEACON;
            res_slot_reg   <= '0;
            res_count_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (hit_reg)
            begin
                res_status_reg <= bsat_pkg::ST_REFRESH;
                res_slot_reg   <= hit_idx_reg;
                res_count_reg  <= new_beacons;
            end
            else if (free_reg)
            begin
                res_status_reg <= bsat_pkg::ST_INSERT;
                res_slot_reg   <= free_idx_reg;
                res_count_reg  <= bsat_pkg::BEACON_W'(1);
            end
            else
            begin
                res_status_reg <= bsat_pkg::ST_FULL;
            end
        end
        if (cmd.probe && hit_now && !hit_reg)
        begin
            hit_idx_reg     <= proc_idx_reg;
            hit_beacons_reg <= beacons_rd_reg;
        end
        // keep the lowest free slot
        if (cmd.probe && free_now && !free_reg)
            free_idx_reg <= proc_idx_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg  <= res_status_reg;
            out_slot_reg    <= bsat_pkg::SLOT_W'(res_slot_reg);
            out_count_reg   <= res_count_reg;
            out_live_reg    <= bsat_pkg::LIVE_W'(live_reg);
            out_removed_reg <= bsat_pkg::REMOVED_W'(removed_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot          = out_slot_reg;
    assign beacon_count  = out_count_reg;
    assign live_count    = out_live_reg;
    assign removed_count = out_removed_reg;

endmodule

// ===== design/beacon_source_aging_table_top.sv =====
// Top level of the beacon source aging table.
// Depends on bsat_pkg, bsat_ctrl and bsat_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_ready   | action, fc_word, source_address
//  out     | out_valid / out_ready | status, slot, beacon_count, live_count, removed_count
//  cfg     | cfg_valid / cfg_ready | cfg_data (max missed ticks)
//
// One item at a time; in_ready is high only while the block is idle.
// A beacon lookup stops at the first matching slot or walks the whole table on a miss;
// a tick walks the whole table; any other frame goes straight to output. The slot memories have
// one read port, so lookup and aging walk the table one slot per cycle.
// Reset clears every slot flag, the live count and the output valid flag at once.
// A stalled output holds its item; the next item is taken meanwhile.
module beacon_source_aging_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [bsat_pkg::FC_W-1:0]           fc_word,
    input  logic [bsat_pkg::ADDR_W-1:0]         source_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bsat_pkg::STATUS_W-1:0]       status,
    output logic [bsat_pkg::SLOT_W-1:0]         slot,
    output logic [bsat_pkg::BEACON_W-1:0]       beacon_count,
    output logic [bsat_pkg::LIVE_W-1:0]         live_count,
    output logic [bsat_pkg::REMOVED_W-1:0]      removed_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bsat_pkg::MISSED_W-1:0]       cfg_data
);

    bsat_pkg::bsat_cmd_t  cmd;
    bsat_pkg::bsat_stat_t stat;

    bsat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsat_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .fc_word        (fc_word),
        .source_address (source_address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .slot           (slot),
        .beacon_count   (beacon_count),
        .live_count     (live_count),
        .removed_count  (removed_count)
    );

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in consecutive cycles");

    a_removed_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != bsat_pkg::ST_TICK) |-> (removed_count == '0))
        else $error("removed count on a frame result");

    a_no_slot_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == bsat_pkg::ST_FULL) || (status == bsat_pkg::ST_NOT_BEACON)
                      || (status == bsat_pkg::ST_TICK))
        |-> (slot == '0) && (beacon_count == '0))
        else $error("slot fields set on a result without a slot");

    a_insert_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == bsat_pkg::ST_INSERT) |-> (beacon_count == 16'd1))
        else $error("inserted entry without a count of one");

endmodule
